[src/load_balanced_queue_assigner_macros.svh]
// Assertion helpers for the RTL. Each expects clk and arst_n in scope.
`ifndef LOAD_BALANCED_QUEUE_ASSIGNER_MACROS_SVH
`define LOAD_BALANCED_QUEUE_ASSIGNER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define LBQA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define LBQA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/lbqa_pkg.sv]
`timescale 1ns / 1ps

package lbqa_pkg;

	// Queue and class codes
	localparam logic [1:0] Q_GRAPHICS = 2'd0;
	localparam logic [1:0] Q_COMPUTE  = 2'd1;
	localparam logic [1:0] Q_COPY     = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_COPY_CLASS_MIN = 2'd0;
	localparam logic [1:0] CFG_COPY_SPILL_MIN = 2'd1;
	localparam logic [1:0] CFG_COPY_KEEP_MIN  = 2'd2;

	// Configuration reset values
	localparam logic [31:0] COPY_CLASS_MIN_RST = 32'd8388608;
	localparam logic [31:0] COPY_SPILL_MIN_RST = 32'd16777216;
	localparam logic [31:0] COPY_KEEP_MIN_RST  = 32'd4194304;

	localparam int COST_W = 20;
	localparam int MEM_W  = 32;
	localparam int LOAD_W = 32;

	typedef struct packed {
		logic [MEM_W-1:0] copy_class_min;
		logic [MEM_W-1:0] copy_spill_min;
		logic [MEM_W-1:0] copy_keep_min;
	} cfg_t;

	// Classified pass handed from front to back
	typedef struct packed {
		logic              new_order;
		logic [1:0]        cls;
		logic              compute_ok;  // 2*gpu > 3*cpu
		logic              spill_big;   // memory above spill threshold
		logic              keep_small;  // memory below keep threshold
		logic [COST_W-1:0] gpu;
		logic [COST_W-1:0] dur;
	} mid_item_t;

	typedef struct packed {
		logic [1:0] queue;
		logic [1:0] preferred_class;
	} result_t;

endpackage

[src/load_balanced_queue_assigner.sv]
`timescale 1ns / 1ps

// Assigns each render pass to the graphics, compute or copy queue. Push one pass
// per cycle while full is low; each pass yields one result (chosen queue and the
// class preferred before balancing), in order, popped while empty is low. The front
// classifier is combinational and the pass is written into a two-entry middle queue
// at the push; the back balancer takes it while the output queue is not full and
// writes the result into the output queue. The sustained rate is one pass per
// cycle while the output queue does not fill; the back balancer updates its loads
// as each pass is taken. Results can wait in the output queue while new passes
// keep being taken until the middle and output queues fill. new_order clears all
// three queue loads before the pass is balanced. Loads are microsecond counts that
// saturate at all ones. The three size thresholds are written through the cfg port
// and take effect for passes pushed after the write; a write to index 3 is ignored.
module load_balanced_queue_assigner #(
	parameter int MID_DEPTH = 2,
	parameter int OUT_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        new_order,
	input  logic [19:0] cpu_cost_us,
	input  logic [19:0] gpu_cost_us,
	input  logic [31:0] footprint_bytes,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  queue,
	output logic [1:0]  preferred_class,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import lbqa_pkg::*;

	cfg_t      cfg_q;
	mid_item_t front_item;
	mid_item_t mid_item;
	logic      mid_empty;
	logic      mid_pop;
	logic      out_full;
	logic      result_push;
	result_t   result;
	result_t   out_result;

	assign cfg_ready = 1'b1;

	// Capture configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.copy_class_min <= COPY_CLASS_MIN_RST;
			cfg_q.copy_spill_min <= COPY_SPILL_MIN_RST;
			cfg_q.copy_keep_min  <= COPY_KEEP_MIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_COPY_CLASS_MIN: cfg_q.copy_class_min <= cfg_data;
				CFG_COPY_SPILL_MIN: cfg_q.copy_spill_min <= cfg_data;
				CFG_COPY_KEEP_MIN:  cfg_q.copy_keep_min  <= cfg_data;
				default: ;
			endcase
		end
	end

	lbqa_front u_front (
		.cfg             (cfg_q),
		.new_order       (new_order),
		.cpu_cost_us     (cpu_cost_us),
		.gpu_cost_us     (gpu_cost_us),
		.footprint_bytes (footprint_bytes),
		.item            (front_item)
	);

	lbqa_queue #(
		.WIDTH ($bits(mid_item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_item),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (mid_item),
		.empty  (mid_empty)
	);

	lbqa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (mid_item),
		.item_valid  (!mid_empty),
		.item_pop    (mid_pop),
		.out_full    (out_full),
		.result_push (result_push),
		.result      (result)
	);

	lbqa_queue #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (result_push),
		.wdata  (result),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_result),
		.empty  (empty)
	);

	assign queue           = out_result.queue;
	assign preferred_class = out_result.preferred_class;

endmodule

[src/lbqa_queue.sv]
`timescale 1ns / 1ps

module lbqa_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entries_q[rd_ptr_q];

	// Store pushed entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/lbqa_front.sv]
`timescale 1ns / 1ps

module lbqa_front (
	input  lbqa_pkg::cfg_t    cfg,
	input  logic              new_order,
	input  logic [19:0]       cpu_cost_us,
	input  logic [19:0]       gpu_cost_us,
	input  logic [31:0]       footprint_bytes,
	output lbqa_pkg::mid_item_t item
);
	import lbqa_pkg::*;

	logic [COST_W:0]   cpu_x2;
	logic [COST_W:0]   gpu_x2;
	logic [COST_W+1:0] cpu_x3;
	logic              gpu_lt_2cpu;
	logic              gpu_gt_2cpu;
	logic              copy_pass;

	// Ratio terms as exact integer products
	assign cpu_x2 = {cpu_cost_us, 1'b0};
	assign gpu_x2 = {gpu_cost_us, 1'b0};
	assign cpu_x3 = {1'b0, cpu_x2} + {2'b00, cpu_cost_us};

	assign gpu_lt_2cpu = {1'b0, gpu_cost_us} < cpu_x2;
	assign gpu_gt_2cpu = {1'b0, gpu_cost_us} > cpu_x2;
	assign copy_pass   = (footprint_bytes > cfg.copy_class_min) && gpu_lt_2cpu;

	// Classify and precompute the size tests the back end needs
	always_comb begin
		item.new_order  = new_order;
		if (copy_pass) begin
			item.cls = Q_COPY;
		end else if (gpu_gt_2cpu) begin
			item.cls = Q_COMPUTE;
		end else begin
			item.cls = Q_GRAPHICS;
		end
		item.compute_ok = {1'b0, gpu_x2} > cpu_x3;
		item.spill_big  = footprint_bytes > cfg.copy_spill_min;
		item.keep_small = footprint_bytes < cfg.copy_keep_min;
		item.gpu        = gpu_cost_us;
		item.dur        = (cpu_cost_us > gpu_cost_us) ? cpu_cost_us : gpu_cost_us;
	end

endmodule

[src/lbqa_back.sv]
`timescale 1ns / 1ps
`include "load_balanced_queue_assigner_macros.svh"

module lbqa_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lbqa_pkg::mid_item_t item,
	input  logic                item_valid,
	output logic                item_pop,
	input  logic                out_full,
	output logic                result_push,
	output lbqa_pkg::result_t   result
);
	import lbqa_pkg::*;

	logic [LOAD_W-1:0] gfx_load_q;
	logic [LOAD_W-1:0] cmp_load_q;
	logic [LOAD_W-1:0] cpy_load_q;
	logic [LOAD_W-1:0] gfx_eff;
	logic [LOAD_W-1:0] cmp_eff;
	logic [LOAD_W-1:0] cpy_eff;
	logic [LOAD_W-1:0] best;
	logic [LOAD_W-1:0] chosen_load;
	logic [LOAD_W:0]   sum_sat;
	logic [LOAD_W-1:0] new_load;
	logic [LOAD_W:0]   cmp_plus_gpu;
	logic [LOAD_W+3:0] spill_lhs;
	logic [LOAD_W+2:0] spill_rhs;
	logic [1:0]        pick;
	logic              fire;

	assign fire        = item_valid && !out_full;
	assign item_pop    = fire;
	assign result_push = fire;

	// Loads as seen by this pass, cleared on a new order
	assign gfx_eff = item.new_order ? '0 : gfx_load_q;
	assign cmp_eff = item.new_order ? '0 : cmp_load_q;
	assign cpy_eff = item.new_order ? '0 : cpy_load_q;

	// Compute spill test: 5*(compute + gpu) > 6*graphics
	assign cmp_plus_gpu = {1'b0, cmp_eff} + {{(LOAD_W + 1 - COST_W){1'b0}}, item.gpu};
	assign spill_lhs    = {1'b0, cmp_plus_gpu, 2'b00} + {3'b000, cmp_plus_gpu};
	assign spill_rhs    = {1'b0, gfx_eff, 2'b00} + {2'b00, gfx_eff, 1'b0};

	// Balance the preferred class against queue loads
	always_comb begin
		pick = item.cls;
		best = gfx_eff;
		case (item.cls)
			Q_GRAPHICS: begin
				if (item.compute_ok && (cmp_eff < gfx_eff)) begin
					best = cmp_eff;
					pick = Q_COMPUTE;
				end
				if (item.spill_big && (cpy_eff < best)) begin
					pick = Q_COPY;
				end
			end
			Q_COMPUTE: begin
				if (spill_lhs > {1'b0, spill_rhs}) begin
					pick = Q_GRAPHICS;
				end
			end
			default: begin
				if (item.keep_small) begin
					pick = Q_GRAPHICS;
				end
			end
		endcase
	end

	// Saturating add of the pass duration
	always_comb begin
		case (pick)
			Q_GRAPHICS: chosen_load = gfx_eff;
			Q_COMPUTE:  chosen_load = cmp_eff;
			default:    chosen_load = cpy_eff;
		endcase
		sum_sat  = {1'b0, chosen_load} + {{(LOAD_W + 1 - COST_W){1'b0}}, item.dur};
		new_load = sum_sat[LOAD_W] ? '1 : sum_sat[LOAD_W-1:0];
	end

	assign result.queue           = pick;
	assign result.preferred_class = item.cls;

	// Update load accumulators on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gfx_load_q <= '0;
			cmp_load_q <= '0;
			cpy_load_q <= '0;
		end else if (fire) begin
			gfx_load_q <= (pick == Q_GRAPHICS) ? new_load : gfx_eff;
			cmp_load_q <= (pick == Q_COMPUTE) ? new_load : cmp_eff;
			cpy_load_q <= (pick == Q_COPY) ? new_load : cpy_eff;
		end
	end

	`LBQA_ASSERT_NEXT(a_loads_hold, !fire,
		$stable(gfx_load_q) && $stable(cmp_load_q) && $stable(cpy_load_q),
		"loads changed without a transfer")
	`LBQA_ASSERT_NEXT(a_gfx_monotonic, fire && !item.new_order && (pick == Q_GRAPHICS),
		gfx_load_q >= $past(gfx_load_q), "graphics load decreased")
	`LBQA_ASSERT_NEXT(a_new_order_clears, fire && item.new_order && (pick == Q_COMPUTE),
		(gfx_load_q == '0) && (cpy_load_q == '0), "new order did not clear loads")
	`LBQA_ASSERT_NOW(a_copy_dest, fire && (item.cls == Q_COPY),
		(pick == Q_COPY) || (pick == Q_GRAPHICS), "copy-like pass sent to compute")

endmodule

[test/load_balanced_queue_assigner_test.sv]
`timescale 1ns / 1ps

module load_balanced_queue_assigner_test;
	import lbqa_pkg::*;

	// Index past the last threshold register; writes to it must be ignored
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	localparam logic [19:0] COST_MAX = '1;
	localparam logic [31:0] MEM_MAX  = '1;
	localparam logic [31:0] LOAD_MAX = '1;

	localparam int SETTLE_CYCLES = 4;
	localparam int QUIET_LIMIT   = 2000;
	localparam int MAX_SHOWN     = 10;
	localparam int SAT_ROUNDS    = 10;
	localparam int NPHASE        = 6;
	localparam int PHASE_PASSES  = 145;

	// Idle percentages per phase: none, sender, receiver, both
	localparam int IDLE_SEND [4] = '{0, 65, 0, 29};
	localparam int IDLE_RECV [4] = '{0, 0, 65, 29};

	typedef enum logic {ROW_PASS, ROW_CFG} row_kind_t;

	// One directed row: a pass, or a threshold write (mem holds the write data)
	typedef struct packed {
		row_kind_t   kind;
		logic        fresh;
		logic [19:0] cpu;
		logic [19:0] gpu;
		logic [31:0] mem;
		logic [1:0]  idx;
		logic        typed;
		result_t     want;
	} dir_row_t;

	typedef struct {
		result_t     res;
		int unsigned pass_no;
	} pick_due_t;

	localparam int NDIR = 28;
	localparam dir_row_t DIRECTED [NDIR] = '{
		// after reset: everything zero lands on graphics
		'{ROW_PASS, 1'b1, '0, '0, '0, '0, 1'b1, '{Q_GRAPHICS, Q_GRAPHICS}},
		// all fields at their maximum: copy-like and large enough to stay on copy
		'{ROW_PASS, 1'b1, COST_MAX, COST_MAX, MEM_MAX, '0, 1'b1, '{Q_COPY, Q_COPY}},
		// compute-like with no graphics load spills to graphics
		'{ROW_PASS, 1'b0, '0, COST_MAX, '0, '0, 1'b1, '{Q_GRAPHICS, Q_COMPUTE}},
		// graphics class balanced toward compute
		'{ROW_PASS, 1'b0, 20'd1, 20'd2, MEM_MAX, '0, 1'b0, '0},
		'{ROW_PASS, 1'b0, 20'd1, 20'd2, MEM_MAX, '0, 1'b0, '0},
		// equal loads after a new order keep graphics
		'{ROW_PASS, 1'b1, 20'd1, 20'd2, MEM_MAX, '0, 1'b0, '0},
		// large graphics pass moves to an idle copy queue
		'{ROW_PASS, 1'b0, '0, '0, MEM_MAX, '0, 1'b0, '0},
		'{ROW_PASS, 1'b0, 20'd3, 20'd4, MEM_MAX, '0, 1'b0, '0},
		// copy-like but below the keep size falls back to graphics
		'{ROW_CFG, 1'b0, '0, '0, MEM_MAX, CFG_COPY_KEEP_MIN, 1'b0, '0},
		'{ROW_PASS, 1'b1, 20'd1, 20'd1, MEM_MAX - 1, '0, 1'b1, '{Q_GRAPHICS, Q_COPY}},
		'{ROW_PASS, 1'b0, 20'd1, 20'd1, MEM_MAX, '0, 1'b1, '{Q_COPY, Q_COPY}},
		// write to the unused index leaves the keep size alone
		'{ROW_CFG, 1'b0, '0, '0, '0, CFG_UNUSED, 1'b0, '0},
		'{ROW_PASS, 1'b0, 20'd1, 20'd1, MEM_MAX - 1, '0, 1'b1, '{Q_GRAPHICS, Q_COPY}},
		// class threshold at its maximum: nothing is copy-like
		'{ROW_CFG, 1'b0, '0, '0, MEM_MAX, CFG_COPY_CLASS_MIN, 1'b0, '0},
		'{ROW_PASS, 1'b0, COST_MAX, '0, MEM_MAX, '0, 1'b0, '0},
		// all thresholds zero
		'{ROW_CFG, 1'b0, '0, '0, '0, CFG_COPY_CLASS_MIN, 1'b0, '0},
		'{ROW_CFG, 1'b0, '0, '0, '0, CFG_COPY_SPILL_MIN, 1'b0, '0},
		'{ROW_CFG, 1'b0, '0, '0, '0, CFG_COPY_KEEP_MIN, 1'b0, '0},
		'{ROW_PASS, 1'b1, 20'd1, '0, 32'd1, '0, 1'b1, '{Q_COPY, Q_COPY}},
		'{ROW_PASS, 1'b0, '0, '0, '0, '0, 1'b0, '0},
		// compute spill compare around the 6/5 ratio
		'{ROW_PASS, 1'b1, '0, 20'd1, '0, '0, 1'b0, '0},
		'{ROW_PASS, 1'b0, '0, 20'd1, '0, '0, 1'b0, '0},
		'{ROW_PASS, 1'b0, '0, 20'd1, '0, '0, 1'b0, '0},
		// restore reset thresholds, after another ignored write
		'{ROW_CFG, 1'b0, '0, '0, MEM_MAX, CFG_UNUSED, 1'b0, '0},
		'{ROW_CFG, 1'b0, '0, '0, COPY_CLASS_MIN_RST, CFG_COPY_CLASS_MIN, 1'b0, '0},
		'{ROW_CFG, 1'b0, '0, '0, COPY_SPILL_MIN_RST, CFG_COPY_SPILL_MIN, 1'b0, '0},
		'{ROW_CFG, 1'b0, '0, '0, COPY_KEEP_MIN_RST, CFG_COPY_KEEP_MIN, 1'b0, '0},
		'{ROW_PASS, 1'b1, '0, '0, '0, '0, 1'b1, '{Q_GRAPHICS, Q_GRAPHICS}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        new_order = 1'b0;
	logic [19:0] cpu_cost_us = '0;
	logic [19:0] gpu_cost_us = '0;
	logic [31:0] footprint_bytes = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  queue;
	logic [1:0]  preferred_class;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// Shadow thresholds and queue loads
	logic [31:0] thr_class = COPY_CLASS_MIN_RST;
	logic [31:0] thr_spill = COPY_SPILL_MIN_RST;
	logic [31:0] thr_keep  = COPY_KEEP_MIN_RST;
	logic [31:0] gfx_load_us  = '0;
	logic [31:0] cmp_load_us  = '0;
	logic [31:0] copy_load_us = '0;

	pick_due_t picks_due [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int n_passes       = 0;
	int n_checked      = 0;
	int n_cfg_writes   = 0;
	int n_mismatches   = 0;
	int n_clipped      = 0;
	int quiet_cycles   = 0;
	int pick_count [3] = '{0, 0, 0};

	load_balanced_queue_assigner dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.new_order       (new_order),
		.cpu_cost_us     (cpu_cost_us),
		.gpu_cost_us     (gpu_cost_us),
		.footprint_bytes (footprint_bytes),
		.empty           (empty),
		.pop             (pop),
		.queue           (queue),
		.preferred_class (preferred_class),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #4 clk = ~clk;

	// Add a pass duration to a load, holding at the ceiling
	function automatic logic [31:0] clip_add(input logic [31:0] load, input logic [19:0] dur);
		logic [32:0] sum;
		sum = 33'(load) + 33'(dur);
		if (sum[32]) begin
			n_clipped++;
			return LOAD_MAX;
		end
		return sum[31:0];
	endfunction

	// Classify one pass, balance it against the loads and charge the chosen queue
	function automatic result_t choose_queue(input logic fresh, input logic [19:0] cpu,
			input logic [19:0] gpu, input logic [31:0] mem);
		logic [63:0] c;
		logic [63:0] g;
		logic [63:0] lhs;
		logic [63:0] rhs;
		logic [31:0] best;
		logic [19:0] dur;
		logic [1:0]  cls;
		logic [1:0]  pick;
		result_t     r;
		if (fresh) begin
			gfx_load_us = '0;
			cmp_load_us = '0;
			copy_load_us = '0;
		end
		c = 64'(cpu);
		g = 64'(gpu);
		if (mem > thr_class && g < 2 * c)
			cls = Q_COPY;
		else if (g > 2 * c)
			cls = Q_COMPUTE;
		else
			cls = Q_GRAPHICS;

		pick = cls;
		case (cls)
			Q_GRAPHICS: begin
				best = gfx_load_us;
				if (2 * g > 3 * c && cmp_load_us < best) begin
					best = cmp_load_us;
					pick = Q_COMPUTE;
				end
				if (mem > thr_spill && copy_load_us < best)
					pick = Q_COPY;
			end
			Q_COMPUTE: begin
				lhs = 5 * (64'(cmp_load_us) + g);
				rhs = 6 * 64'(gfx_load_us);
				if (lhs > rhs)
					pick = Q_GRAPHICS;
			end
			default: begin
				if (mem < thr_keep)
					pick = Q_GRAPHICS;
			end
		endcase

		dur = (cpu > gpu) ? cpu : gpu;
		case (pick)
			Q_GRAPHICS: gfx_load_us = clip_add(gfx_load_us, dur);
			Q_COMPUTE:  cmp_load_us = clip_add(cmp_load_us, dur);
			default:    copy_load_us = clip_add(copy_load_us, dur);
		endcase
		pick_count[pick]++;
		r.queue = pick;
		r.preferred_class = cls;
		return r;
	endfunction

	// Offer one pass and log its expected result on transfer; push stays high afterward
	task automatic send_pass(input logic fresh, input logic [19:0] cpu, input logic [19:0] gpu,
			input logic [31:0] mem, input logic typed, input result_t fixed_res);
		result_t   r;
		pick_due_t due;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		new_order <= fresh;
		cpu_cost_us <= cpu;
		gpu_cost_us <= gpu;
		footprint_bytes <= mem;
		@(posedge clk);
		while (full)
			@(posedge clk);
		r = choose_queue(fresh, cpu, gpu, mem);
		if (typed)
			r = fixed_res;
		due.res = r;
		due.pass_no = unsigned'(n_passes);
		picks_due.insert(picks_due.size(), due);
		n_passes++;
	endtask

	// Write one threshold register; cfg_valid stays high afterward
	task automatic write_threshold(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		n_cfg_writes++;
		case (idx)
			CFG_COPY_CLASS_MIN: thr_class = data;
			CFG_COPY_SPILL_MIN: thr_spill = data;
			CFG_COPY_KEEP_MIN:  thr_keep = data;
			default: ;
		endcase
	endtask

	// Wait for every expected result, then let the pipeline empty out
	task automatic settle;
		while (picks_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic flag_mismatch(input string what);
		n_mismatches++;
		if (n_mismatches <= MAX_SHOWN)
			$display("%0t mismatch: %s", $time, what);
	endtask

	// Receiver: stall pop at the phase's rate
	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin
		pick_due_t due;
		if (arst_n && pop && !empty) begin
			n_checked++;
			if (picks_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected result queue=%0d class=%0d",
					queue, preferred_class));
			end else begin
				due = picks_due.pop_front();
				if (queue !== due.res.queue)
					flag_mismatch($sformatf("pass %0d queue: expected %0d, got %0d",
						due.pass_no, due.res.queue, queue));
				if (preferred_class !== due.res.preferred_class)
					flag_mismatch($sformatf("pass %0d class: expected %0d, got %0d",
						due.pass_no, due.res.preferred_class, preferred_class));
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, picks_due.size());
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic        fresh;
		logic [19:0] cpu;
		logic [19:0] gpu;
		logic [21:0] rel;
		logic [31:0] mem;
		logic [31:0] cls_v;
		logic [31:0] spill_v;
		logic [31:0] keep_v;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; threshold rows wait for the block to go idle
		for (int i = 0; i < NDIR; i++) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				if (i == 0 || DIRECTED[i-1].kind != ROW_CFG) begin
					push <= 1'b0;
					settle();
				end
				write_threshold(DIRECTED[i].idx, DIRECTED[i].mem);
			end else begin
				if (i > 0 && DIRECTED[i-1].kind == ROW_CFG)
					cfg_valid <= 1'b0;
				send_pass(DIRECTED[i].fresh, DIRECTED[i].cpu, DIRECTED[i].gpu,
					DIRECTED[i].mem, DIRECTED[i].typed, DIRECTED[i].want);
			end
		end

		// Build up all three loads with back-to-back maximum-cost passes
		for (int k = 0; k < 3 * SAT_ROUNDS; k++) begin
			case (k % 3)
				0: send_pass(k == 0, COST_MAX, COST_MAX, '0, 1'b0, '0);
				1: send_pass(1'b0, '0, COST_MAX, '0, 1'b0, '0);
				default: send_pass(1'b0, COST_MAX, COST_MAX, MEM_MAX, 1'b0, '0);
			endcase
		end
		push <= 1'b0;

		// Random phases, each with its own thresholds and idle pattern
		for (int p = 0; p < NPHASE; p++) begin
			settle();
			case (p)
				0: begin
					cls_v = COPY_CLASS_MIN_RST;
					spill_v = COPY_SPILL_MIN_RST;
					keep_v = COPY_KEEP_MIN_RST;
				end
				1: begin
					cls_v = '0;
					spill_v = '0;
					keep_v = '0;
				end
				2: begin
					cls_v = MEM_MAX;
					spill_v = MEM_MAX;
					keep_v = MEM_MAX;
				end
				default: begin
					cls_v = $urandom_range(32'h0200_0000);
					spill_v = $urandom_range(32'h0200_0000);
					keep_v = $urandom_range(32'h0400_0000);
				end
			endcase
			write_threshold(CFG_COPY_CLASS_MIN, cls_v);
			write_threshold(CFG_COPY_SPILL_MIN, spill_v);
			write_threshold(CFG_COPY_KEEP_MIN, keep_v);
			write_threshold(CFG_UNUSED, $urandom);
			cfg_valid <= 1'b0;
			send_idle_pct = IDLE_SEND[p % 4];
			recv_stall_pct = IDLE_RECV[p % 4];

			for (int n = 0; n < PHASE_PASSES; n++) begin
				// long orders so the loads build up between clears
				fresh = ($urandom_range(39) == 0);
				case ($urandom_range(3))
					0: cpu = 20'($urandom_range(255));
					1: cpu = 20'($urandom);
					2: cpu = $urandom_range(1) ? COST_MAX : '0;
					default: cpu = 20'($urandom_range(65535));
				endcase
				// place gpu near the 2x and 1.5x boundaries most of the time
				case ($urandom_range(4))
					0: rel = 22'(cpu) * 22'd2;
					1: rel = 22'(cpu) * 22'd2 + 22'd1;
					2: rel = 22'(cpu) * 22'd2 - 22'd1;
					3: rel = (22'(cpu) * 22'd3) / 22'd2 + 22'($urandom_range(2)) - 22'd1;
					default: rel = 22'($urandom_range(COST_MAX));
				endcase
				gpu = (rel > 22'(COST_MAX)) ? COST_MAX : rel[19:0];
				// place memory near one of the current thresholds in three of seven cases
				case ($urandom_range(6))
					0: mem = thr_class + 32'($urandom_range(2)) - 1;
					1: mem = thr_spill + 32'($urandom_range(2)) - 1;
					2: mem = thr_keep + 32'($urandom_range(2)) - 1;
					3: mem = $urandom_range(1) ? MEM_MAX : '0;
					4: mem = $urandom_range(32'h0400_0000);
					default: mem = $urandom;
				endcase
				send_pass(fresh, cpu, gpu, mem, 1'b0, '0);
			end
			push <= 1'b0;
		end

		settle();
		$display("Sent %0d passes (%0d max-cost), %0d results checked, %0d threshold writes",
			n_passes, 3 * SAT_ROUNDS, n_checked, n_cfg_writes);
		$display("Picks gfx/compute/copy %0d/%0d/%0d, clipped load updates %0d, mismatches %0d",
			pick_count[Q_GRAPHICS], pick_count[Q_COMPUTE], pick_count[Q_COPY], n_clipped,
			n_mismatches);
		if (n_mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
